### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the escaper checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

### rtl/js_esc_pkg.sv
// ---------------------------------------------------------------------------
// js_esc_pkg
// Types, character codes and helpers for the string escaper.
// ---------------------------------------------------------------------------
package js_esc_pkg;

   localparam int UNIT_W = 16;
   localparam int IDX_W  = 3;

   localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [UNIT_W-1:0] CH_SQUOTE    = 16'h0027;
   localparam logic [UNIT_W-1:0] CH_DQUOTE    = 16'h0022;
   localparam logic [UNIT_W-1:0] CH_BACKTICK  = 16'h0060;
   localparam logic [UNIT_W-1:0] CH_DOLLAR    = 16'h0024;
   localparam logic [UNIT_W-1:0] CH_LF        = 16'h000A;
   localparam logic [UNIT_W-1:0] CH_CR        = 16'h000D;
   localparam logic [UNIT_W-1:0] CH_TAB       = 16'h0009;
   localparam logic [UNIT_W-1:0] CH_LSEP      = 16'h2028;
   localparam logic [UNIT_W-1:0] CH_PSEP      = 16'h2029;
   localparam logic [UNIT_W-1:0] CH_CTRL_END  = 16'h0020;
   localparam logic [UNIT_W-1:0] CH_N         = 16'h006E;
   localparam logic [UNIT_W-1:0] CH_R         = 16'h0072;
   localparam logic [UNIT_W-1:0] CH_T         = 16'h0074;
   localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;

   localparam logic [IDX_W-1:0] IDX_FIRST     = 3'd0;
   localparam logic [IDX_W-1:0] IDX_PAIR_LAST = 3'd1;
   localparam logic [IDX_W-1:0] IDX_NIB3      = 3'd2;
   localparam logic [IDX_W-1:0] IDX_NIB2      = 3'd3;
   localparam logic [IDX_W-1:0] IDX_NIB1      = 3'd4;
   localparam logic [IDX_W-1:0] IDX_NIB0      = 3'd5;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_PAIR,
      KIND_HEX
   } esc_kind_type;

   typedef struct packed {
      logic              busy;
      logic [UNIT_W-1:0] unit;
      logic [IDX_W-1:0]  idx;
   } run_type;

   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              last;
   } sel_type;

   function automatic logic [UNIT_W-1:0] hex_char(input logic [3:0] nib);
      logic [UNIT_W-1:0] res;
      if (nib < 4'd10) begin
         res = 16'h0030 + {12'd0, nib};
      end else begin
         res = 16'h0057 + {12'd0, nib};
      end
      return res;
   endfunction

endpackage

### rtl/js_esc_req_if.sv
// ---------------------------------------------------------------------------
// js_esc_req_if
// Input channel: one UTF-16 code unit per item.
// ---------------------------------------------------------------------------
interface js_esc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

### rtl/js_esc_rsp_if.sv
// ---------------------------------------------------------------------------
// js_esc_rsp_if
// Result channel: one escaped code unit per item, last unit of a run marked.
// ---------------------------------------------------------------------------
interface js_esc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        run_last;

   modport source (output valid, output out_unit, output run_last, input ready);
   modport sink   (input valid, input out_unit, input run_last, output ready);
endinterface

### rtl/js_esc_classify.sv
// ---------------------------------------------------------------------------
// js_esc_classify
// Decode the held code unit and pick the escaped unit at the run position.
// ---------------------------------------------------------------------------
module js_esc_classify
   import js_esc_pkg::*;
(
   input  run_type run,
   output sel_type sel
);

   esc_kind_type      kind;
   logic [UNIT_W-1:0] pair_char;
   logic [3:0]        nib;

   always_comb begin
      pair_char = run.unit;
      unique case (run.unit) inside
         CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_BACKTICK, CH_DOLLAR: begin
            kind = KIND_PAIR;
         end
         CH_LF: begin
            kind      = KIND_PAIR;
            pair_char = CH_N;
         end
         CH_CR: begin
            kind      = KIND_PAIR;
            pair_char = CH_R;
         end
         CH_TAB: begin
            kind      = KIND_PAIR;
            pair_char = CH_T;
         end
         CH_LSEP, CH_PSEP: begin
            kind = KIND_HEX;
         end
         default: begin
            kind = (run.unit < CH_CTRL_END) ? KIND_HEX : KIND_PLAIN;
         end
      endcase
   end

   always_comb begin
      case (run.idx)
         IDX_NIB3: nib = run.unit[15:12];
         IDX_NIB2: nib = run.unit[11:8];
         IDX_NIB1: nib = run.unit[7:4];
         default:  nib = run.unit[3:0];
      endcase
   end

   always_comb begin
      unique case (kind)
         KIND_PAIR: begin
            sel.unit = (run.idx == IDX_FIRST) ? CH_BACKSLASH : pair_char;
            sel.last = (run.idx == IDX_PAIR_LAST);
         end
         KIND_HEX: begin
            if (run.idx == IDX_FIRST) begin
               sel.unit = CH_BACKSLASH;
            end else if (run.idx == IDX_PAIR_LAST) begin
               sel.unit = CH_U;
            end else begin
               sel.unit = hex_char(nib);
            end
            sel.last = (run.idx == IDX_NIB0);
         end
         default: begin
            sel.unit = run.unit;
            sel.last = 1'b1;
         end
      endcase
   end

endmodule

### rtl/js_esc_emit.sv
// ---------------------------------------------------------------------------
// js_esc_emit
// Run and result registers: hold one input item, step through its escaped
// units and present one unit per cycle while the result channel is free.
// ---------------------------------------------------------------------------
module js_esc_emit
   import js_esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   js_esc_req_if.sink   req_if,
   js_esc_rsp_if.source rsp_if,
   input  sel_type      sel,
   output run_type      run
);

   logic              run_valid_ff, run_valid_in;
   logic [UNIT_W-1:0] run_unit_ff, run_unit_in;
   logic [IDX_W-1:0]  run_idx_ff, run_idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [UNIT_W-1:0] out_unit_ff, out_unit_in;
   logic              out_last_ff, out_last_in;

   logic out_free;
   logic advance;
   logic run_done;
   logic accept;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign advance      = run_valid_ff && out_free;
   assign run_done     = advance && sel.last;
   assign req_if.ready = !run_valid_ff || run_done;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      run_valid_in = run_valid_ff;
      run_unit_in  = run_unit_ff;
      run_idx_in   = run_idx_ff;
      if (accept) begin
         run_valid_in = 1'b1;
         run_unit_in  = req_if.code_unit;
         run_idx_in   = IDX_FIRST;
      end else if (run_done) begin
         run_valid_in = 1'b0;
      end else if (advance) begin
         run_idx_in = run_idx_ff + 3'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_unit_in  = out_unit_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_unit_in  = sel.unit;
         out_last_in  = sel.last;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_unit_ff <= run_unit_in;
      run_idx_ff  <= run_idx_in;
      out_unit_ff <= out_unit_in;
      out_last_ff <= out_last_in;
   end

   assign run.busy        = run_valid_ff;
   assign run.unit        = run_unit_ff;
   assign run.idx         = run_idx_ff;
   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_unit = out_unit_ff;
   assign rsp_if.run_last = out_last_ff;

endmodule

### rtl/js_string_escape.sv
// ---------------------------------------------------------------------------
// js_string_escape
// Escapes UTF-16 code units for JavaScript string and template literals.
// ---------------------------------------------------------------------------
// Each input item is one code unit; it yields one, two or six result items,
// the last one flagged by run_last. Ordinary units stream at one item per
// clock while the result channel does not stall. A two-unit escape (quotes,
// backslash, backtick, dollar, \n, \r, \t) or a \uXXXX escape holds the block
// for all its units, as the result register takes at most one unit per cycle
// and the next input item is taken in the cycle the last unit of the current
// run moves to that register. Input and result sides are separated by the
// run register and the result register; no state survives between items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module js_string_escape
   import js_esc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   js_esc_req_if.sink   req_if,
   js_esc_rsp_if.source rsp_if
);

   run_type run;
   sel_type sel;

   js_esc_classify u_classify (
      .run (run),
      .sel (sel)
   );

   js_esc_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .sel    (sel),
      .run    (run)
   );

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_if.valid && req_if.ready, run.busy)
   `ASSERT_IMPLY(a_idle_ready, clock, reset, !run.busy, req_if.ready)
   `ASSERT_IMPLY(a_run_pending, clock, reset, rsp_if.valid && !rsp_if.run_last, run.busy)
   `ASSERT_IMPLY(a_escape_lead, clock, reset, run.busy && run.idx == IDX_FIRST && !sel.last, sel.unit == CH_BACKSLASH)

endmodule

### tb/tb_js_string_escape.sv
// ---------------------------------------------------------------------------
// tb_js_string_escape
// Self-checking testbench for the JavaScript string escaper. Directed corner
// units are sent first, then about 500 random units weighted toward escapes.
// A scoreboard predicts the one, two or six escaped units for each accepted
// item and compares them, in order, with what the block emits. Both sides
// idle and stall at random in the first two of three phases, and the
// sender drains the block before each phase.
// ---------------------------------------------------------------------------
module tb_js_string_escape;
   import js_esc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 170;
   localparam int SETTLE_TICKS = 20;

   localparam logic [UNIT_W-1:0] DIGIT_ZERO = 16'h0030;
   localparam logic [UNIT_W-1:0] LETTER_A   = 16'h0061;

   class escape_scoreboard;
      typedef struct {
         logic [UNIT_W-1:0] unit;
         logic              last;
      } esc_unit_type;

      esc_unit_type pending[$];
      int           failures;
      int           items_noted;
      int           units_checked;
      int           by_kind[3];

      function logic [UNIT_W-1:0] nibble_char(logic [3:0] nib);
         if (nib < 4'd10) begin
            return DIGIT_ZERO + UNIT_W'(nib);
         end
         return LETTER_A + UNIT_W'(nib) - UNIT_W'(10);
      endfunction

      function void push_unit(logic [UNIT_W-1:0] unit, logic last);
         esc_unit_type e;
         e.unit = unit;
         e.last = last;
         pending.insert(pending.size(), e);
      endfunction

      function void note_input(logic [UNIT_W-1:0] cu);
         esc_kind_type      kind;
         logic [UNIT_W-1:0] second;
         kind   = KIND_PAIR;
         second = cu;
         case (cu) inside
            CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_BACKTICK, CH_DOLLAR: second = cu;
            CH_LF: second = CH_N;
            CH_CR: second = CH_R;
            CH_TAB: second = CH_T;
            default: begin
               if (cu < CH_CTRL_END || cu == CH_LSEP || cu == CH_PSEP) begin
                  kind = KIND_HEX;
               end else begin
                  kind = KIND_PLAIN;
               end
            end
         endcase
         case (kind)
            KIND_PLAIN: push_unit(cu, 1'b1);
            KIND_PAIR: begin
               push_unit(CH_BACKSLASH, 1'b0);
               push_unit(second, 1'b1);
            end
            default: begin
               push_unit(CH_BACKSLASH, 1'b0);
               push_unit(CH_U, 1'b0);
               for (int i = 3; i >= 0; i--) begin
                  push_unit(nibble_char(cu[i*4 +: 4]), i == 0);
               end
            end
         endcase
         by_kind[int'(kind)]++;
         items_noted++;
      endfunction

      function void check_result(logic [UNIT_W-1:0] unit, logic last);
         esc_unit_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: out_unit=%h run_last=%b", unit, last);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (unit !== want.unit) begin
            $error("out_unit mismatch: expected %h, actual %h", want.unit, unit);
            failures++;
         end
         if (last !== want.last) begin
            $error("run_last mismatch: expected %b, actual %b", want.last, last);
            failures++;
         end
         units_checked++;
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   send_idle_pct;
   int   recv_stall_pct;

   escape_scoreboard escapes = new();

   js_esc_req_if req_ch ();
   js_esc_rsp_if rsp_ch ();

   js_string_escape DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         escapes.note_input(req_ch.code_unit);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         escapes.check_result(rsp_ch.out_unit, rsp_ch.run_last);
      end
   end

   task automatic send_unit(input logic [UNIT_W-1:0] cu);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.code_unit <= cu;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (escapes.pending.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [UNIT_W-1:0] pick_unit();
      logic [UNIT_W-1:0] specials[8];
      specials = '{CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_BACKTICK,
                   CH_DOLLAR, CH_LF, CH_CR, CH_TAB};
      case ($urandom_range(9))
         0, 1, 2, 3: return UNIT_W'($urandom());
         4, 5: return UNIT_W'($urandom_range(16'h007E, 16'h0020));
         6, 7: return specials[$urandom_range(7)];
         8: return UNIT_W'($urandom_range(16'h001F, 16'h0000));
         default: begin
            case ($urandom_range(3))
               0: return CH_LSEP;
               1: return CH_PSEP;
               2: return UNIT_W'($urandom_range(16'hDFFF, 16'hD800));
               default: return UNIT_W'($urandom_range(16'h202A, 16'h2026));
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [UNIT_W-1:0] corner_units[$];
      int                idle_plan[3][2];
      corner_units = '{16'h0000, 16'hFFFF, 16'h001F, CH_CTRL_END, CH_BACKSLASH,
                       CH_SQUOTE, CH_DQUOTE, CH_BACKTICK, CH_DOLLAR, CH_LF, CH_CR,
                       CH_TAB, CH_LSEP, CH_PSEP, 16'h2027, 16'h202A, 16'hD800,
                       16'hDC00, 16'hDBFF, 16'hDFFF, 16'h0041, 16'h001B,
                       16'h7FFF, 16'h8000};
      idle_plan = '{'{14, 53}, '{53, 14}, '{0, 0}};
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.code_unit <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 3; p++) begin
         drain_block();
         send_idle_pct  = idle_plan[p][0];
         recv_stall_pct = idle_plan[p][1];
         if (p == 0) begin
            foreach (corner_units[i]) begin
               send_unit(corner_units[i]);
            end
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) begin
               drain_block();
            end
            send_unit(pick_unit());
         end
      end

      drain_block();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (escapes.pending.size() != 0) begin
         $error("%0d expected units never arrived", escapes.pending.size());
         escapes.failures++;
      end

      $display("Escaped %0d code units into %0d results in %0d cycles.",
               escapes.items_noted, escapes.units_checked, cycles);
      $display("Plain: %0d, two-unit escapes: %0d, \\u escapes: %0d.",
               escapes.by_kind[int'(KIND_PLAIN)], escapes.by_kind[int'(KIND_PAIR)],
               escapes.by_kind[int'(KIND_HEX)]);
      if (escapes.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
